// ----- sv/pfe_pkg.sv -----
// Package for the postfix expression evaluator: status codes, sequencer states,
// character constants and the divider status struct.
// Depends on nothing; every other file but pfe_if imports it.
package pfe_pkg;

	// Result status codes, in the order the result channel encodes them.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNDERFLOW  = 3'd1,
		ST_OVERFLOW   = 3'd2,
		ST_DIVZERO    = 3'd3,
		ST_UNBALANCED = 3'd4
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIVW,
		S_FRD,
		S_FIN
	} state_t;

	// Characters that the evaluator recognizes.
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Status of the divider, seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- sv/pfe_if.sv -----
// Channel interfaces of the postfix expression evaluator: the symbol stream in
// and the result stream out. Depends on nothing.
interface pfe_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_of_expression;

	modport source(output valid, output symbol, output end_of_expression, input ready);
	modport sink(input valid, input symbol, input end_of_expression, output ready);
endinterface

interface pfe_res_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [2:0]                   status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

// ----- sv/pfe_divider.sv -----
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg for the status struct.
module pfe_divider import pfe_pkg::*; #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [W-1:0] quotient,
	output div_stat_t    stat
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] count_q;
	logic          done_q;
	logic          neg_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    rem_shift;
	logic [W:0]    rem_sub;
	logic [W-1:0]  num_mag;
	logic [W-1:0]  den_mag;

	// Operand magnitudes; the most negative value maps to its own bit pattern,
	// which is correct as an unsigned magnitude.
	assign num_mag = num[W-1] ? (~num + W'(1)) : num;
	assign den_mag = den[W-1] ? (~den + W'(1)) : den;

	// One restoring step. The remainder stays below the divisor, so it fits
	// in W bits and only the shifted value needs the extra bit.
	assign rem_shift = {rem_q, quo_q[W-1]};
	assign rem_sub   = rem_shift - {1'b0, den_q};

	// Control: count the steps and flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (count_q == CW'(1));
			if (start) begin
				count_q <= CW'(W);
			end else if (count_q != '0) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Datapath: the dividend shifts out of the quotient register as bits enter.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W-1] ^ den[W-1];
			quo_q <= num_mag;
			den_q <= den_mag;
			rem_q <= '0;
		end else if (count_q != '0) begin
			if (!rem_sub[W]) begin
				rem_q <= rem_sub[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = neg_q ? (~quo_q + W'(1)) : quo_q;
	assign stat.busy = (count_q != '0);
	assign stat.done = done_q;

endmodule

// ----- sv/postfix_expression_evaluator_core.sv -----
// Postfix expression evaluator top level: stack memory, sequencer and result
// register. Depends on pfe_pkg, pfe_if and pfe_divider.
//
// Usage: characters of a postfix expression arrive as beats on the expr
// channel, one character per beat, the last one marked by end_of_expression.
// A digit pushes its value onto a stack of signed VALUE_BITS-bit entries; any
// other character pops two operands and pushes their sum, difference, product,
// truncated quotient, or zero for an unknown symbol. After the marked beat
// one result beat (value, status) leaves on the result channel.
// Steps per character: a digit is pushed as it is taken; +, - and * first
// read both operands from the two-port synchronous stack, then compute and
// write back; / waits on the one-bit-per-cycle divider and takes no character meanwhile.
// After the marked character the bottom entry is read from the stack
// memory and the result register is loaded.
// After an error the remaining characters up to the mark are taken unevaluated.
// The result sits in an output register, so a stalled receiver holds only the
// next expression's end: characters are still taken until a second result
// would have to be loaded.
// Reset clears the stack depth, the error code and the result valid flag; the
// stack memory itself needs no clearing since only pushed entries are read.
module postfix_expression_evaluator_core import pfe_pkg::*; #(
	parameter int STACK_ENTRIES = 64,
	parameter int VALUE_BITS    = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	pfe_sym_if.sink         expr,
	pfe_res_if.source       result
);

	localparam int W  = VALUE_BITS;
	localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
	localparam int DW = $clog2(STACK_ENTRIES + 1);

	state_t          state_q, state_d;
	logic [DW-1:0]   depth_q, depth_d;
	status_t         err_q, err_d;
	logic [7:0]      sym_q;
	logic            last_q;

	logic [W-1:0]    stack_mem [STACK_ENTRIES];
	logic [W-1:0]    rd_r_q, rd_l_q;
	logic [AW-1:0]   raddr_r, raddr_l;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [W-1:0]    mem_wdata;

	logic [DW-1:0]   depth_m1, depth_m2;
	logic            accept;
	logic            is_digit;
	logic [7:0]      digit;
	logic [W-1:0]    prod_low;
	logic [W-1:0]    alu_res;

	logic            div_start;
	logic [W-1:0]    div_quo;
	div_stat_t       div_stat;

	logic            out_load;
	logic            out_valid_q;
	logic [W-1:0]    out_value_q;
	status_t         out_status_q;
	status_t         fin_status;

	assign accept   = expr.valid && expr.ready;
	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign is_digit = (expr.symbol >= CH_0) && (expr.symbol <= CH_9);
	assign digit    = expr.symbol - CH_0;

	// Stack read addresses: top two entries, or the bottom entry at the end.
	assign raddr_r = depth_m1[AW-1:0];
	assign raddr_l = (state_q == S_FRD || state_q == S_FIN) ? '0 : depth_m2[AW-1:0];

	// Stack memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		rd_r_q <= stack_mem[raddr_r];
		rd_l_q <= stack_mem[raddr_l];
	end

	// Arithmetic on the two operands read from the stack; the product wraps
	// to the entry width.
	assign prod_low = rd_l_q * rd_r_q;
	always_comb begin
		case (sym_q)
			CH_PLUS:  alu_res = rd_l_q + rd_r_q;
			CH_MINUS: alu_res = rd_l_q - rd_r_q;
			CH_STAR:  alu_res = prod_low;
			default:  alu_res = '0;
		endcase
	end

	pfe_divider #(
		.W(W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (rd_l_q),
		.den     (rd_r_q),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// Final status of the expression.
	assign fin_status = (err_q == ST_OK && depth_q != DW'(1)) ? ST_UNBALANCED : err_q;

	// Sequencer state register and item latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= expr.symbol;
			last_q <= expr.end_of_expression;
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d    = state_q;
		depth_d    = depth_q;
		err_d      = err_q;
		mem_we     = 1'b0;
		mem_waddr  = depth_m2[AW-1:0];
		mem_wdata  = alu_res;
		div_start  = 1'b0;
		out_load   = 1'b0;
		expr.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				expr.ready = 1'b1;
				if (expr.valid) begin
					state_d = expr.end_of_expression ? S_FRD : S_IDLE;
					if (err_q == ST_OK) begin
						if (is_digit) begin
							if (depth_q >= DW'(STACK_ENTRIES)) begin
								err_d = ST_OVERFLOW;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = depth_q[AW-1:0];
								mem_wdata = W'(digit);
								depth_d   = depth_q + DW'(1);
							end
						end else if (depth_q < DW'(2)) begin
							err_d = ST_UNDERFLOW;
						end else begin
							state_d = S_EXEC;
						end
					end
				end
			end
			S_EXEC: begin
				if (sym_q == CH_SLASH) begin
					if (rd_r_q == '0) begin
						err_d   = ST_DIVZERO;
						state_d = last_q ? S_FRD : S_IDLE;
					end else begin
						div_start = 1'b1;
						state_d   = S_DIVW;
					end
				end else begin
					mem_we  = 1'b1;
					depth_d = depth_m1;
					state_d = last_q ? S_FRD : S_IDLE;
				end
			end
			S_DIVW: begin
				if (div_stat.done) begin
					mem_we    = 1'b1;
					mem_wdata = div_quo;
					depth_d   = depth_m1;
					state_d   = last_q ? S_FRD : S_IDLE;
				end
			end
			S_FRD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					depth_d  = '0;
					err_d    = ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result register: holds one beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= fin_status;
			out_value_q  <= (fin_status == ST_OK) ? rd_l_q : '0;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

	// The stack depth never passes the number of entries.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_ENTRIES))
		else $error("stack depth beyond capacity");

	// An error result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != ST_OK) |-> (result.value == '0))
		else $error("error result with nonzero value");

	// The divider is idle whenever a new character can be taken.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_stat.busy)
		else $error("divider busy while taking characters");

	// The first error of an expression is kept until the result is loaded.
	a_err_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !out_load) |=> (err_q == $past(err_q)))
		else $error("pending error overwritten");

	// The result register is loaded only when it is free or being emptied.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !out_load)
		else $error("result overwritten while stalled");

endmodule

// ----- tb/pfe_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the postfix expression evaluator: watches both channels,
// evaluates every accepted character on its own stack and compares each result beat.
// Depends on pfe_pkg and the channel interfaces in pfe_if.
module pfe_checker import pfe_pkg::*; #(
	parameter int STACK_ENTRIES = 64,
	parameter int VALUE_BITS    = 32
) (
	input  logic clk,
	input  logic arst_n,
	pfe_sym_if   sym,
	pfe_res_if   res,
	output int   mismatches,
	output int   outstanding
);

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		status_t                      status;
	} eval_result_t;

	// Shadow copy of the evaluation state.
	logic signed [VALUE_BITS-1:0] operand_stack [STACK_ENTRIES];
	int                           stack_level = 0;
	status_t                      first_error = ST_OK;
	eval_result_t                 results_due[$];

	int fail_count   = 0;
	int due_count    = 0;
	int result_beats = 0;

	assign mismatches  = fail_count;
	assign outstanding = due_count;

	// Counts a failure; only the first ten are printed.
	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Applies one character to the shadow stack and, on the marked character,
	// queues the result the block has to produce.
	task automatic evaluate_symbol(input logic [7:0] ch, input logic last);
		logic signed [VALUE_BITS-1:0] lhs;
		logic signed [VALUE_BITS-1:0] rhs;
		logic signed [VALUE_BITS-1:0] folded;
		longint                       quotient;
		eval_result_t                 outcome;

		if (first_error == ST_OK) begin
			if (ch >= CH_0 && ch <= CH_9) begin
				if (stack_level >= STACK_ENTRIES) begin
					first_error = ST_OVERFLOW;
				end else begin
					operand_stack[stack_level] = VALUE_BITS'(ch - CH_0);
					stack_level++;
				end
			end else if (stack_level < 2) begin
				first_error = ST_UNDERFLOW;
			end else begin
				rhs = operand_stack[stack_level-1];
				lhs = operand_stack[stack_level-2];
				stack_level -= 2;
				folded = '0;
				case (ch)
					CH_PLUS:  folded = lhs + rhs;
					CH_MINUS: folded = lhs - rhs;
					CH_STAR:  folded = lhs * rhs;
					CH_SLASH: begin
						// Wide division so that the most negative value over -1
						// wraps back to itself instead of trapping.
						if (rhs == 0) begin
							first_error = ST_DIVZERO;
						end else begin
							quotient = longint'(lhs) / longint'(rhs);
							folded = quotient[VALUE_BITS-1:0];
						end
					end
					default:  folded = '0;
				endcase
				if (first_error == ST_OK) begin
					operand_stack[stack_level] = folded;
					stack_level++;
				end
			end
		end

		if (last) begin
			outcome.status = first_error;
			if (outcome.status == ST_OK && stack_level != 1)
				outcome.status = ST_UNBALANCED;
			outcome.value = (outcome.status == ST_OK) ? operand_stack[0] : '0;
			results_due.push_back(outcome);
			stack_level = 0;
			first_error = ST_OK;
		end
	endtask

	// Prediction on every symbol beat, comparison on every result beat.
	always @(posedge clk or negedge arst_n) begin : watch
		eval_result_t due;

		if (!arst_n) begin
			stack_level = 0;
			first_error = ST_OK;
			results_due.delete();
		end else begin
			if (sym.valid && sym.ready)
				evaluate_symbol(sym.symbol, sym.end_of_expression);
			if (res.valid && res.ready) begin
				if (results_due.size() == 0) begin
					report_failure($sformatf("result beat %0d with nothing due: value %0d status %0d",
						result_beats, res.value, res.status));
				end else begin
					due = results_due.pop_front();
					if (res.value !== due.value || res.status !== due.status)
						report_failure($sformatf(
							"result beat %0d: value %0d expected %0d, status %0d expected %0d",
							result_beats, res.value, due.value, res.status, due.status));
				end
				result_beats++;
			end
		end
		due_count = results_due.size();
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for postfix_expression_evaluator_core: drives expressions with random
// gaps and back-pressure and gives the verdict. Depends on pfe_pkg, pfe_if, pfe_checker.
module tb;
	import pfe_pkg::*;

	localparam int STACK_ENTRIES = 64;
	localparam int VALUE_BITS    = 32;
	// Allow far more than any correct run, a divide or the long receiver hold
	// included, ever spends without a beat on either channel.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;

	localparam logic [7:0] CH_1     = CH_0 + 8'd1;
	localparam logic [7:0] CH_2     = CH_0 + 8'd2;

	typedef logic [7:0] text_t[$];

	logic clk;
	logic arst_n;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_req      = 1'b0;
	bit   hold_done     = 1'b0;
	int   chars_sent    = 0;
	int   quiet_cycles  = 0;
	int   mismatches;
	int   outstanding;

	pfe_sym_if                            sym_ch ();
	pfe_res_if #(.VALUE_BITS(VALUE_BITS)) res_ch ();

	postfix_expression_evaluator_core #(
		.STACK_ENTRIES(STACK_ENTRIES),
		.VALUE_BITS   (VALUE_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.expr  (sym_ch),
		.result(res_ch)
	);

	pfe_checker #(
		.STACK_ENTRIES(STACK_ENTRIES),
		.VALUE_BITS   (VALUE_BITS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym        (sym_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run once no beat has moved for too long.
	always @(posedge clk) begin
		if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result receiver: random back-pressure, plus one long hold on request.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one character and waits for its beat; valid stays up afterwards.
	task automatic send_char(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			sym_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sym_ch.valid             <= 1'b1;
		sym_ch.symbol            <= ch;
		sym_ch.end_of_expression <= last;
		@(posedge clk);
		while (!sym_ch.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_expr(input text_t chars);
		foreach (chars[i])
			send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		text_t chars;

		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
		send_expr(chars);
	endtask

	function automatic logic [7:0] random_digit();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] CH_4_or_digit(input int d);
		return CH_0 + 8'(d);
	endfunction

	// Mostly the four arithmetic operators, now and then an unknown symbol.
	function automatic logic [7:0] random_operator();
		int          pick;
		logic [7:0]  ch;

		pick = $urandom_range(99);
		if (pick < 26) return CH_PLUS;
		if (pick < 52) return CH_MINUS;
		if (pick < 78) return CH_STAR;
		if (pick < 96) return CH_SLASH;
		do ch = 8'($urandom_range(255)); while (ch >= CH_0 && ch <= CH_9);
		return ch;
	endfunction

	// Well-formed postfix text with random digits and operators; once in a while
	// one that pushes near or past the stack size before reducing.
	function automatic text_t random_expr();
		text_t chars;
		int    level;
		int    goal;
		int    deep_pushes;

		level = 0;
		if ($urandom_range(39) == 0) begin
			deep_pushes = $urandom_range(STACK_ENTRIES - 6, STACK_ENTRIES + 2);
			repeat (deep_pushes) chars.push_back(random_digit());
			repeat (deep_pushes - 1) chars.push_back(random_operator());
		end else begin
			goal = $urandom_range(1, 25);
			while (chars.size() < goal || level != 1) begin
				if (level < 2 || (chars.size() < goal && $urandom_range(99) < 50)) begin
					chars.push_back(random_digit());
					level++;
				end else begin
					chars.push_back(random_operator());
					level--;
				end
			end
		end
		return chars;
	endfunction

	// Mostly well-formed expressions, some broken ones and some raw noise.
	task automatic run_phase(input int char_target);
		text_t chars;
		int    pick;

		while (chars_sent < char_target) begin
			pick = $urandom_range(99);
			chars = random_expr();
			if (pick >= 80 && pick < 90) begin
				case ($urandom_range(2))
					0: if (chars.size() > 1) void'(chars.pop_back());
					1: chars.push_front(random_operator());
					default: chars.push_back(random_digit());
				endcase
			end else if (pick >= 90) begin
				chars.delete();
				repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(255)));
			end
			send_expr(chars);
		end
	endtask

	initial begin
		text_t chars;
		text_t power_of_two;

		sym_ch.valid             <= 1'b0;
		sym_ch.symbol            <= '0;
		sym_ch.end_of_expression <= 1'b0;
		arst_n                   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single digits, each operator, truncation toward zero.
		send_text("7");
		send_text("0");
		send_text("9");
		send_text("12+");
		send_text("93-");
		send_text("39-");
		send_text("99*");
		send_text("84/");
		send_text("27-2/");
		send_text("72-02-/");
		// Error cases: divide by zero, underflow, first error kept, unbalanced.
		send_text("50/");
		send_text("+");
		send_text("1+");
		send_text("1+23+");
		send_text("12");
		// Unknown symbols, including the byte extremes, yield zero.
		send_text("45:");
		send_expr({CH_4_or_digit(4), CH_4_or_digit(5), 8'h00});
		send_expr({CH_4_or_digit(4), CH_4_or_digit(5), 8'hFF});

		// Push on a full stack overflows; exactly full still evaluates.
		chars.delete();
		repeat (STACK_ENTRIES + 1) chars.push_back(CH_1);
		send_expr(chars);
		chars.delete();
		repeat (STACK_ENTRIES) chars.push_back(CH_9);
		repeat (STACK_ENTRIES - 1) chars.push_back(CH_PLUS);
		send_expr(chars);

		// 2 to the 31st wraps to the most negative value; divided by -1 it stays
		// there, minus one it wraps to the most positive value.
		power_of_two = {CH_2};
		repeat (VALUE_BITS - 2) begin
			power_of_two.push_back(CH_2);
			power_of_two.push_back(CH_STAR);
		end
		send_expr({power_of_two, CH_0, CH_1, CH_MINUS, CH_SLASH});
		send_expr({power_of_two, CH_1, CH_MINUS});

		// Random phases with different idling on each side.
		send_idle_pct = 22;
		recv_idle_pct = 54;
		run_phase(630);
		send_idle_pct = 54;
		recv_idle_pct = 22;
		run_phase(990);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 1'b1;
		run_phase(1350);
		sym_ch.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/pfe_pkg.sv
sv/pfe_if.sv
sv/pfe_divider.sv
sv/postfix_expression_evaluator_core.sv
tb/pfe_checker.sv
tb/tb.sv
